// File: design/sli_pkg.sv
// Shared types and constants for the sorted insertion list.
`timescale 1ns / 1ps

package sli_pkg;

  // Number of cells in the chain, one stored value each.
  localparam int CAPACITY = 16;
  // Width of the fill counter: it must hold CAPACITY itself.
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  // Width of the position and count fields of a result word.
  localparam int FIELD_W  = 5;
  localparam int KIND_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // Flags that one cell hands to its right-hand neighbour.
  typedef struct packed {
    logic cond;  // this cell is at or beyond the insert slot
    logic eq;    // this cell holds a live copy of the searched value
  } sli_link_t;

endpackage

// File: design/sli_cell.sv
// One cell of the sorted chain: stores a value, compares it and shifts right on insert.
`timescale 1ns / 1ps

module sli_cell
  import sli_pkg::*;
(
  input  logic                      clk,
  input  logic                      occupied,    // cell index lies below the fill count
  input  logic                      shift_en,    // an accepted insert is being applied
  input  logic signed [VALUE_W-1:0] key,         // value of the item under execution
  input  logic signed [VALUE_W-1:0] left_value,  // stored value of the left neighbour
  input  sli_link_t                 link_i,      // flags of the left neighbour
  output logic signed [VALUE_W-1:0] value_o,
  output sli_link_t                 link_o,
  output logic                      first_o      // first live match in the chain
);

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;

  // The insert slot is the first cell that is empty or holds a greater value.
  // Cells to its right take their neighbour's value, the slot takes the key.
  always_comb begin
    link_o.cond = !occupied || (value_r > key);
    link_o.eq   = occupied && (value_r == key);
    first_o     = link_o.eq && !link_i.eq;
    value_nxt   = value_r;
    if (shift_en) begin
      if (link_i.cond) begin
        value_nxt = left_value;
      end else if (link_o.cond) begin
        value_nxt = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;

endmodule

// File: design/sorted_list_insert_find_top.sv
// Top level of the sorted insertion list: input stage, cell chain, fill count and result register.
`timescale 1ns / 1ps

// Sorted insertion list. The block keeps up to CAPACITY signed 32-bit values in
// ascending order in a chain of cells, one value per cell. Each input word
// carries a kind in in_tuser and a value in in_tdata: an insert places the value
// after any equal ones, a find returns the 1-based position of the first match
// (0 when absent) and a clear empties the list. Every input word gives exactly
// one result word with ok in out_tuser and the position and the count after the
// item in out_tdata. An insert into a full list is refused with ok low and the
// list unchanged. An accepted word is held in an input register, then all cells
// compare against it at once and shift right by one place on an insert, and the
// result is written to the output register. One word per cycle is taken for as
// long as the result side keeps up. The output register stalls the execute step
// when its word is not taken, and in_tready drops while the input register is
// holding a word that cannot execute. Stored values that lie beyond the count
// are never looked at, so the cells need no clearing after reset.

module sorted_list_insert_find_top
  import sli_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value (signed)
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] position, [9:5] count, [15:10] zero
  output logic        out_tuser   // [0] ok
);

  localparam int PAD_W = 16 - 2 * FIELD_W;

  // Input register: the word waiting to execute.
  logic                      busy_r;
  logic                      busy_nxt;
  kind_t                     kind_r;
  logic signed [VALUE_W-1:0] value_r;

  // Number of live values in the chain.
  logic [CNT_W-1:0]          fill_r;
  logic [CNT_W-1:0]          fill_nxt;

  // Result register.
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      ok_r;
  logic                      ok_nxt;
  logic [FIELD_W-1:0]        pos_r;
  logic [FIELD_W-1:0]        pos_nxt;
  logic [FIELD_W-1:0]        count_r;
  logic [FIELD_W-1:0]        count_nxt;

  logic                      in_fire;
  logic                      out_free;
  logic                      exec;
  logic                      full;
  logic                      shift_en;
  logic                      found;
  logic [CNT_W-1:0]          match_pos;

  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  sli_link_t                 cell_link  [CAPACITY];
  logic [CAPACITY-1:0]       first;

  // The result register is free when empty or when its word leaves now; the
  // waiting word executes exactly then, which also frees the input register.
  assign out_free  = !out_valid_r || out_tready;
  assign exec      = busy_r && out_free;
  assign in_tready = !busy_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign full      = (fill_r == CNT_W'(CAPACITY));
  assign shift_en  = exec && (kind_r == KIND_INSERT) && !full;

  // The chain of cells. The leftmost cell sees an empty neighbour that is never
  // past the insert slot and never matches.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value;
    sli_link_t                 left_link;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_link  = '0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_link  = cell_link[i-1];
    end

    sli_cell u_cell (
      .clk        (clk),
      .occupied   (CNT_W'(i) < fill_r),
      .shift_en   (shift_en),
      .key        (value_r),
      .left_value (left_value),
      .link_i     (left_link),
      .value_o    (cell_value[i]),
      .link_o     (cell_link[i]),
      .first_o    (first[i])
    );
  end

  // Equal values sit next to each other, so at most one cell flags the first
  // match and its position can be gathered with a plain OR.
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        match_pos = match_pos | CNT_W'(i + 1);
      end
    end
  end
  assign found = |first;

  always_comb begin
    busy_nxt      = busy_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    ok_nxt        = ok_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (exec) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      ok_nxt        = 1'b0;
      pos_nxt       = '0;
      case (kind_r)
        KIND_INSERT: begin
          if (!full) begin
            fill_nxt = fill_r + CNT_W'(1);
            ok_nxt   = 1'b1;
          end
        end
        KIND_FIND: begin
          ok_nxt  = found;
          pos_nxt = FIELD_W'(match_pos);
        end
        KIND_CLEAR: begin
          fill_nxt = '0;
          ok_nxt   = 1'b1;
        end
        default: begin
          // Unused kind: no change, refused.
          ok_nxt = 1'b0;
        end
      endcase
      count_nxt = FIELD_W'(fill_nxt);
    end

    if (in_fire) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= kind_t'(in_tuser);
      value_r <= in_tdata;
    end
    ok_r    <= ok_nxt;
    pos_r   <= pos_nxt;
    count_r <= count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ok_r;
  assign out_tdata  = {PAD_W'(0), count_r, pos_r};

endmodule

// File: design/sli_checker.sv
// Port-level checker for the sorted insertion list, bound to the top level.
`timescale 1ns / 1ps

module sli_checker
  import sli_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:5] <= FIELD_W'(CAPACITY))
    else $error("count beyond capacity");

  // A reported position is a hit and lies within the list.
  a_pos_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] != 5'd0 |-> out_tuser && out_tdata[4:0] <= out_tdata[9:5])
    else $error("position without a hit or beyond the count");

  // An accepted input word carries no unknown bits.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !$isunknown({in_tuser, in_tdata}))
    else $error("unknown bits in an accepted input word");

  // No result word is shown straight after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_list_insert_find_top sli_checker u_sli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: bench/sorted_list_insert_find_top_tb.sv
// Self-checking testbench for the sorted insertion list top level.
`timescale 1ns / 1ps

module sorted_list_insert_find_top_tb;
  import sli_pkg::*;

  // Kind code that the block must ignore.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_WORDS  = 1750;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int PRINT_LIMIT   = 50;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] count;
  } list_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  // Own copy of the list contents, kept in ascending order.
  logic signed [VALUE_W-1:0] sorted_values[$];
  // Results still owed by the block, oldest first.
  list_result_t              pending_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  sorted_list_insert_find_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_list_insert_find_top verification failed");
      $finish;
    end
  end

  // Applies one item to the local list and returns the result it should give.
  function automatic list_result_t apply_list_item(logic [KIND_W-1:0] kind,
                                                   logic signed [VALUE_W-1:0] value);
    list_result_t res;
    int           slot;
    res = '0;
    case (kind)
      KIND_INSERT: begin
        if (sorted_values.size() < CAPACITY) begin
          // Equal values stay ahead of the new one.
          slot = sorted_values.size();
          for (int i = 0; i < sorted_values.size(); i++) begin
            if (sorted_values[i] > value) begin
              slot = i;
              break;
            end
          end
          sorted_values.insert(slot, value);
          res.ok = 1'b1;
        end
      end
      KIND_FIND: begin
        for (int i = 0; i < sorted_values.size(); i++) begin
          if (sorted_values[i] == value) begin
            res.position = FIELD_W'(i + 1);
            res.ok       = 1'b1;
            break;
          end
        end
      end
      KIND_CLEAR: begin
        sorted_values.delete();
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.count = FIELD_W'(sorted_values.size());
    return res;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Sends one word, with random idle cycles ahead of it, and records the
  // expected result once the word has been taken.
  task automatic send_word(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= 2'($urandom);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_list_item(kind, value));
  endtask

  // The receiver stalls at random; the stall decision changes on the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.ok)
          report_mismatch("ok", out_tuser, want.ok);
        if (out_tdata[4:0] !== want.position)
          report_mismatch("position", out_tdata[4:0], want.position);
        if (out_tdata[9:5] !== want.count)
          report_mismatch("count", out_tdata[9:5], want.count);
        if (out_tdata[15:10] !== 6'd0)
          report_mismatch("padding", out_tdata[15:10], 0);
      end
    end
  end

  // Empty list: a miss, an ignored kind, a clear with nothing to clear.
  task automatic test_empty_list();
    send_word(KIND_FIND, 32'd0);
    send_word(KIND_UNUSED, VAL_MAX);
    send_word(KIND_CLEAR, VAL_MIN);
  endtask

  // Fills the list to capacity with extremes and duplicates, then checks the
  // refused insert, first-match positions and a clear carrying a value.
  task automatic test_fill_and_refuse();
    send_word(KIND_INSERT, VAL_MAX);
    send_word(KIND_INSERT, VAL_MIN);
    send_word(KIND_INSERT, 32'd0);
    send_word(KIND_INSERT, 32'd0);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'd1);
    send_word(KIND_INSERT, VAL_MAX);
    send_word(KIND_INSERT, VAL_MIN);
    repeat (CAPACITY - 8) send_word(KIND_INSERT, $urandom);
    send_word(KIND_INSERT, 32'd5);
    send_word(KIND_UNUSED, 32'd0);
    send_word(KIND_FIND, VAL_MIN);
    send_word(KIND_FIND, VAL_MAX);
    send_word(KIND_FIND, 32'd0);
    send_word(KIND_CLEAR, VAL_MAX);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3, 4: return VALUE_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Mostly inserts and finds, so the list often reaches full; clears are rare.
  task automatic test_random_traffic(int unsigned words);
    int unsigned      roll;
    logic [KIND_W-1:0] kind;
    logic [VALUE_W-1:0] value;
    repeat (words) begin
      roll  = $urandom_range(0, 99);
      value = pick_value();
      if (roll < 55) begin
        kind = KIND_INSERT;
      end else if (roll < 93) begin
        kind = KIND_FIND;
        // Half of the finds look for a value known to be stored.
        if (sorted_values.size() != 0 && $urandom_range(0, 1))
          value = sorted_values[$urandom_range(0, sorted_values.size() - 1)];
      end else if (roll < 97) begin
        kind = KIND_CLEAR;
      end else begin
        kind = KIND_UNUSED;
      end
      send_word(kind, value);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 10;
    recv_stall_pct = 48;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_fill_and_refuse();
    test_random_traffic(RANDOM_WORDS / 3);
    send_idle_pct  = 48;
    recv_stall_pct = 10;
    test_random_traffic(RANDOM_WORDS / 3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

    @(negedge clk);
    in_tvalid <= 1'b0;
    // Keep the receiver ready so the last words drain.
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("sorted_list_insert_find_top verification clean");
    end else begin
      $display("sorted_list_insert_find_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/sli_pkg.sv
design/sli_cell.sv
design/sorted_list_insert_find_top.sv
design/sli_checker.sv
bench/sorted_list_insert_find_top_tb.sv
